[rtl/cfcd_pkg.sv]
// Package for the COBS frame checksum decoder.
// Holds the frame size limit, the event and result codes and the queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package cfcd_pkg;

  // Largest number of bytes kept in one frame; later bytes are dropped.
  localparam int MAX_FRAME = 1024;
  // Byte position counter width: it must be able to hold MAX_FRAME itself.
  localparam int POS_W = $clog2(MAX_FRAME + 1);

  localparam int SUM_W = 16;
  localparam int LEN_W = 10;

  typedef enum logic {
    EV_BYTE = 1'b0,
    EV_IDLE = 1'b1
  } event_kind_t;

  typedef enum logic {
    RK_PAYLOAD = 1'b0,
    RK_STATUS  = 1'b1
  } result_kind_t;

  typedef enum logic [2:0] {
    FS_OK        = 3'd0,
    FS_SHORT     = 3'd1,
    FS_BAD_START = 3'd2,
    FS_BAD_END   = 3'd3,
    FS_COBS_ZERO = 3'd4,
    FS_COBS_TRUNC = 3'd5,
    FS_CHECKSUM  = 3'd6
  } frame_status_t;

  typedef enum logic [1:0] {
    CE_NONE      = 2'd0,
    CE_ZERO_DATA = 2'd1,
    CE_ZERO_CODE = 2'd2
  } cobs_error_t;

  // Delimiter byte of the framing and the code byte of a full COBS group.
  localparam logic [7:0] COBS_DELIM = 8'h00;
  localparam logic [7:0] COBS_FULL  = 8'hFF;

  // Minimum frame: start byte, two checksum bytes and the terminator.
  localparam int MIN_FRAME = 4;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  data;
  } event_t;

  // Handshake between the event queue and the decoder.
  typedef struct packed {
    logic   valid;
    event_t item;
  } queue_head_t;

endpackage

[rtl/cfcd_event_if.sv]
// Stream interfaces for the COBS frame checksum decoder: input events and results.
// Depends on nothing; payload fields are plain vectors at the field widths.
`timescale 1ns / 1ps

interface cfcd_event_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [7:0] rx_byte;

  modport source (output valid, output event_kind, output rx_byte, input ready);
  modport sink (input valid, input event_kind, input rx_byte, output ready);
endinterface

interface cfcd_result_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic [2:0] frame_status;
  logic [9:0] payload_length;

  modport source (output valid, output result_kind, output payload_byte,
                  output frame_status, output payload_length, input ready);
  modport sink (input valid, input result_kind, input payload_byte,
                input frame_status, input payload_length, output ready);
endinterface

[rtl/cobs_frame_checksum_decoder.sv]
// Top level of the COBS frame checksum decoder: event queue in front, decoder behind.
// Depends on cfcd_pkg, cfcd_event_if, cfcd_result_if, cfcd_queue and cfcd_decoder.
`timescale 1ns / 1ps

// Channel     Direction  Beat contents
// event_in    in         event_kind (byte or line idle), rx_byte
// result_out  out        result_kind, payload_byte, frame_status, payload_length
//
// A steady stream sustains one beat per cycle while result_out takes its beats.
// An accepted event is registered in a queue entry, and any result beat it yields is
// then registered in the single result register as the decoder's frame state updates.
// rst is synchronous and active high; it empties the queue, clears the frame state and
// drops any pending result. No clearing pass is needed.
// A stalled result_out holds the decoder; the two-entry queue keeps event_in ready until
// both entries are full.

module cobs_frame_checksum_decoder
  import cfcd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  cfcd_event_if.sink    event_in,
  cfcd_result_if.source result_out
);

  event_t        in_item;
  queue_head_t   head;
  logic          pop;
  result_kind_t  out_kind;
  frame_status_t out_status;

  // Incoming events are only buffered here; all frame decisions live in the decoder.
  assign in_item.kind = event_kind_t'(event_in.event_kind);
  assign in_item.data = event_in.rx_byte;

  cfcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (event_in.valid),
    .in_ready (event_in.ready),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  // The decoder owns the frame state and the output register that parts it from the sink.
  cfcd_decoder u_decoder (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_kind   (out_kind),
    .out_byte   (result_out.payload_byte),
    .out_status (out_status),
    .out_length (result_out.payload_length)
  );

  assign result_out.result_kind  = out_kind;
  assign result_out.frame_status = out_status;

  // A payload beat never carries status or length.
  a_payload_clean : assert property (@(posedge clk) disable iff (rst)
    result_out.valid && out_kind == RK_PAYLOAD
      |-> out_status == FS_OK && result_out.payload_length == '0)
    else $error("payload beat carries status fields");

  // A status beat never carries a data byte.
  a_status_clean : assert property (@(posedge clk) disable iff (rst)
    result_out.valid && out_kind == RK_STATUS |-> result_out.payload_byte == 8'd0)
    else $error("status beat carries a payload byte");

  // Reset leaves the queue empty, so events are taken right after it.
  a_ready_after_reset : assert property (@(posedge clk)
    rst |=> event_in.ready)
    else $error("event_in not ready after reset");

  // No result appears in the cycle after reset.
  a_no_result_after_reset : assert property (@(posedge clk)
    rst |=> !result_out.valid)
    else $error("result beat right after reset");

endmodule

[rtl/cfcd_queue.sv]
// Front part of the COBS frame checksum decoder: accepts events into a two-entry queue.
// Depends on cfcd_pkg.
`timescale 1ns / 1ps

module cfcd_queue
  import cfcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  event_t      in_item,
  output queue_head_t head,
  input  logic        pop
);

  event_t     entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       do_pop;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

endmodule

[rtl/cfcd_decoder.sv]
// Back part of the COBS frame checksum decoder: frame state, COBS decode, checksum
// and the result register. Depends on cfcd_pkg.
`timescale 1ns / 1ps

module cfcd_decoder
  import cfcd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  queue_head_t   head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output result_kind_t  out_kind,
  output logic [7:0]    out_byte,
  output frame_status_t out_status,
  output logic [LEN_W-1:0] out_length
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             start_ok, start_ok_next;
  logic [SUM_W-1:0] expected_sum, expected_sum_next;
  logic [SUM_W-1:0] running_sum, running_sum_next;
  logic [7:0]       group_remaining, group_remaining_next;
  logic             zero_pending, zero_pending_next;
  logic             held_terminator, held_terminator_next;
  cobs_error_t      cobs_error, cobs_error_next;
  logic [7:0]       last_byte, last_byte_next;
  logic [POS_W-1:0] decoded_count, decoded_count_next;

  logic          emit;
  logic [7:0]    emit_val;
  logic          res_valid;
  result_kind_t  res_kind;
  frame_status_t status;

  // The result register frees itself when taken, so one event can retire per cycle.
  assign pop = head.valid && (!out_valid || out_ready);

  always_comb begin
    priority if (byte_position < POS_W'(MIN_FRAME)) begin
      status = FS_SHORT;
    end else if (!start_ok) begin
      status = FS_BAD_START;
    end else if (!held_terminator || last_byte != COBS_DELIM) begin
      status = FS_BAD_END;
    end else if (cobs_error != CE_NONE) begin
      status = FS_COBS_ZERO;
    end else if (group_remaining != 8'd0) begin
      status = FS_COBS_TRUNC;
    end else if (running_sum != expected_sum) begin
      status = FS_CHECKSUM;
    end else begin
      status = FS_OK;
    end
  end

  always_comb begin
    byte_position_next   = byte_position;
    start_ok_next        = start_ok;
    expected_sum_next    = expected_sum;
    running_sum_next     = running_sum;
    group_remaining_next = group_remaining;
    zero_pending_next    = zero_pending;
    held_terminator_next = held_terminator;
    cobs_error_next      = cobs_error;
    last_byte_next       = last_byte;
    decoded_count_next   = decoded_count;
    emit                 = 1'b0;
    emit_val             = 8'd0;
    res_valid            = 1'b0;
    res_kind             = RK_PAYLOAD;

    if (head.item.kind == EV_IDLE) begin
      res_valid            = 1'b1;
      res_kind             = RK_STATUS;
      byte_position_next   = '0;
      start_ok_next        = 1'b0;
      expected_sum_next    = '0;
      running_sum_next     = '0;
      group_remaining_next = 8'd0;
      zero_pending_next    = 1'b0;
      held_terminator_next = 1'b0;
      cobs_error_next      = CE_NONE;
      last_byte_next       = 8'd0;
      decoded_count_next   = '0;
    end else if (byte_position < POS_W'(MAX_FRAME)) begin
      // The held byte is decoded now that this byte shows it was not the terminator.
      if (byte_position >= POS_W'(MIN_FRAME) && cobs_error != CE_ZERO_CODE) begin
        if (group_remaining == 8'd0) begin
          zero_pending_next = 1'b0;
          if (last_byte == COBS_DELIM) begin
            cobs_error_next = CE_ZERO_CODE;
          end else begin
            group_remaining_next = last_byte - 8'd1;
            zero_pending_next    = (last_byte != COBS_FULL);
          end
          emit     = zero_pending;
          emit_val = 8'd0;
        end else begin
          group_remaining_next = group_remaining - 8'd1;
          if (last_byte == COBS_DELIM && cobs_error == CE_NONE) begin
            cobs_error_next = CE_ZERO_DATA;
          end
          emit     = 1'b1;
          emit_val = last_byte;
        end
      end
      if (emit) begin
        running_sum_next   = running_sum + {8'd0, emit_val};
        decoded_count_next = decoded_count + POS_W'(1);
      end
      res_valid = emit;

      if (byte_position == POS_W'(0)) begin
        start_ok_next = (head.item.data == COBS_DELIM);
      end else if (byte_position == POS_W'(1)) begin
        expected_sum_next[7:0] = head.item.data;
      end else if (byte_position == POS_W'(2)) begin
        expected_sum_next[15:8] = head.item.data;
      end
      last_byte_next       = head.item.data;
      held_terminator_next = (byte_position >= POS_W'(3));
      byte_position_next   = byte_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      start_ok        <= 1'b0;
      expected_sum    <= '0;
      running_sum     <= '0;
      group_remaining <= 8'd0;
      zero_pending    <= 1'b0;
      held_terminator <= 1'b0;
      cobs_error      <= CE_NONE;
      last_byte       <= 8'd0;
      decoded_count   <= '0;
    end else if (pop) begin
      byte_position   <= byte_position_next;
      start_ok        <= start_ok_next;
      expected_sum    <= expected_sum_next;
      running_sum     <= running_sum_next;
      group_remaining <= group_remaining_next;
      zero_pending    <= zero_pending_next;
      held_terminator <= held_terminator_next;
      cobs_error      <= cobs_error_next;
      last_byte       <= last_byte_next;
      decoded_count   <= decoded_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_kind <= res_kind;
      if (res_kind == RK_STATUS) begin
        out_byte   <= 8'd0;
        out_status <= status;
        out_length <= decoded_count[LEN_W-1:0];
      end else begin
        out_byte   <= emit_val;
        out_status <= FS_OK;
        out_length <= '0;
      end
    end
  end

endmodule
